FILE: rtl/kvbt_pkg.sv
// Package for the paged key/value block table manager.
// Holds shared widths, command and status codes, register indexes and the geometry struct.
// No dependencies.
`default_nettype none

package kvbt_pkg;

    localparam int NUM_BLOCKS_DEF         = 1024;
    localparam int MAX_BLOCKS_PER_SEQ_DEF = 64;
    localparam int NUM_SEQ_SLOTS_DEF      = 16;

    localparam int CMD_W      = 3;
    localparam int ID_W       = 64;
    localparam int TOK_W      = 15;
    localparam int LAYER_W    = 7;
    localparam int STATUS_W   = 3;
    localparam int ADDR_W     = 47;
    localparam int FREE_W     = 11;
    localparam int TPB_W      = 9;
    localparam int HC_W       = 8;
    localparam int HW_W       = 9;
    localparam int LC_W       = 8;
    localparam int BASE_W     = 46;
    localparam int REF_W      = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 46;
    localparam int DVD_W      = 16;

    localparam logic [REF_W-1:0] REF_MAX = 5'd31;

    typedef enum logic [CMD_W-1:0] {
        CMD_CREATE     = 3'd0,
        CMD_FREE       = 3'd1,
        CMD_APPEND     = 3'd2,
        CMD_FORK       = 3'd3,
        CMD_KEY_ADDR   = 3'd4,
        CMD_VALUE_ADDR = 3'd5
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_EXISTS    = 3'd2,
        ST_TOO_LONG  = 3'd3,
        ST_NO_BLOCKS = 3'd4,
        ST_NO_SLOT   = 3'd5,
        ST_BAD_POS   = 3'd6
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TPB       = 3'd0,
        CFG_HEADS     = 3'd1,
        CFG_HEAD_W    = 3'd2,
        CFG_LAYERS    = 3'd3,
        CFG_POOL_BASE = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [TPB_W-1:0]  tpb;
        logic [HC_W-1:0]   hc;
        logic [HW_W-1:0]   hw;
        logic [LC_W-1:0]   lc;
        logic [BASE_W-1:0] base;
    } t_geom;

endpackage

`default_nettype wire

FILE: rtl/paged_kv_block_table_manager.sv
// Top level of the paged key/value block table manager.
// Depends on kvbt_pkg, kvbt_div and kvbt_addr.
`default_nettype none

// Usage. A command word is taken at a rising edge where start is high and busy is
// low. The block then works on it alone and keeps busy high until it has issued the
// one result word, which sits on the o_ result ports for exactly one cycle with
// o_valid high. The receiver cannot stall; it must take the word in that cycle.
// The next command may be presented in the same cycle that the result is shown.
//
// Work per command. Every command first scans all NUM_SEQ_SLOTS slot tags, one per
// cycle. Create with a nonzero token count, append, fork and address translation
// then run a division by tokens per block, unless the scan results reject them.
// Append and create pop a key block and a value block per new list position, free
// walks every entry of both lists, fork copies each shared list position, and
// address translation reads the list and then runs the address pipeline. The
// loops over the key and value lists set the rate: each step is a read, modify and
// write of the list, reference count and free stack memories, with registered reads.
//
// Reset. i_rst_n is synchronous and active low. After it, a clearing pass fills
// the free stack with 0 .. NUM_BLOCKS-1 and zeroes the reference counts; busy
// stays high during that pass. Configuration writes are taken at any time, one
// per cycle, and must only be made while the block is idle.

module paged_kv_block_table_manager #(
    parameter int NUM_BLOCKS         = kvbt_pkg::NUM_BLOCKS_DEF,
    parameter int MAX_BLOCKS_PER_SEQ = kvbt_pkg::MAX_BLOCKS_PER_SEQ_DEF,
    parameter int NUM_SEQ_SLOTS      = kvbt_pkg::NUM_SEQ_SLOTS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [kvbt_pkg::CMD_W-1:0]        i_cmd,
    input  wire logic [kvbt_pkg::ID_W-1:0]         i_sequence_id,
    input  wire logic [kvbt_pkg::ID_W-1:0]         i_child_sequence_id,
    input  wire logic [kvbt_pkg::TOK_W-1:0]        i_token_count,
    input  wire logic [kvbt_pkg::LAYER_W-1:0]      i_layer_index,
    input  wire logic [kvbt_pkg::TOK_W-1:0]        i_token_position,
    input  wire logic                              i_cfg_we,
    input  wire logic [kvbt_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [kvbt_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                                   o_valid,
    output logic [kvbt_pkg::STATUS_W-1:0]          o_status,
    output logic [kvbt_pkg::ADDR_W-1:0]            o_element_address,
    output logic [kvbt_pkg::TOK_W-1:0]             o_sequence_length,
    output logic [kvbt_pkg::FREE_W-1:0]            o_free_block_count
);

    localparam int BLK_W      = $clog2(NUM_BLOCKS);
    localparam int TOP_W      = $clog2(NUM_BLOCKS + 1);
    localparam int SLOT_W     = (NUM_SEQ_SLOTS > 1) ? $clog2(NUM_SEQ_SLOTS) : 1;
    localparam int LIST_DEPTH = NUM_SEQ_SLOTS * MAX_BLOCKS_PER_SEQ;
    localparam int LIST_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int BC_W       = $clog2(MAX_BLOCKS_PER_SEQ + 1);
    localparam int TOK_W      = kvbt_pkg::TOK_W;
    localparam int ID_W       = kvbt_pkg::ID_W;
    localparam int REF_W      = kvbt_pkg::REF_W;
    localparam int DVD_W      = kvbt_pkg::DVD_W;
    localparam int TPB_W      = kvbt_pkg::TPB_W;

    localparam logic [LIST_W-1:0] MAX_L     = LIST_W'(MAX_BLOCKS_PER_SEQ);
    localparam logic [16:0]       MAX_N     = 17'(MAX_BLOCKS_PER_SEQ);
    localparam logic [TOP_W-1:0]  TOP_FULL  = TOP_W'(NUM_BLOCKS);
    localparam logic [TOP_W-1:0]  CLR_LAST  = TOP_W'(NUM_BLOCKS - 1);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(NUM_SEQ_SLOTS - 1);

    typedef enum logic [18:0] {
        S_CLR  = 19'(1) << 0,
        S_IDLE = 19'(1) << 1,
        S_SCAN = 19'(1) << 2,
        S_DISP = 19'(1) << 3,
        S_DIV  = 19'(1) << 4,
        S_CHK  = 19'(1) << 5,
        S_POPR = 19'(1) << 6,
        S_POPW = 19'(1) << 7,
        S_RLL  = 19'(1) << 8,
        S_RLR  = 19'(1) << 9,
        S_RLU  = 19'(1) << 10,
        S_CPR  = 19'(1) << 11,
        S_CPK  = 19'(1) << 12,
        S_CPKW = 19'(1) << 13,
        S_CPVR = 19'(1) << 14,
        S_CPVW = 19'(1) << 15,
        S_TRR  = 19'(1) << 16,
        S_TRA  = 19'(1) << 17,
        S_DONE = 19'(1) << 18
    } t_state;

    // Configuration registers.
    logic [TPB_W-1:0]            r_tpb;
    logic [kvbt_pkg::HC_W-1:0]   r_hc;
    logic [kvbt_pkg::HW_W-1:0]   r_hw;
    logic [kvbt_pkg::LC_W-1:0]   r_lc;
    logic [kvbt_pkg::BASE_W-1:0] r_base;
    logic [TPB_W-1:0]            tpb_eff;
    kvbt_pkg::t_geom             geom;

    // Sequencer state and the latched command word.
    t_state                      r_state;
    logic [TOP_W-1:0]            r_clr;
    logic [TOP_W-1:0]            r_top;
    kvbt_pkg::t_cmd              r_cmd;
    logic [ID_W-1:0]             r_id;
    logic [ID_W-1:0]             r_child;
    logic [TOK_W-1:0]            r_count;
    logic [kvbt_pkg::LAYER_W-1:0] r_layer;
    logic [TOK_W-1:0]            r_pos;

    // Scan results.
    logic [SLOT_W-1:0]           r_sc;
    logic                        r_f;
    logic                        r_cf;
    logic                        r_ef;
    logic [SLOT_W-1:0]           r_fs;
    logic [SLOT_W-1:0]           r_es;
    logic [SLOT_W-1:0]           r_ts;
    logic [TOK_W-1:0]            r_len;
    logic [BC_W-1:0]             r_bc;

    // Loop control.
    logic [BC_W-1:0]             r_i;
    logic [BC_W-1:0]             r_end;
    logic                        r_vph;
    logic [BLK_W-1:0]            r_blk;
    logic [BLK_W-1:0]            r_blk2;

    // Result word.
    logic                        r_ovalid;
    kvbt_pkg::t_status           r_st;
    logic [kvbt_pkg::ADDR_W-1:0] r_oaddr;
    logic [TOK_W-1:0]            r_olen;

    // Slot table.
    logic [NUM_SEQ_SLOTS-1:0]    r_valid;
    logic [ID_W-1:0]             r_tag    [NUM_SEQ_SLOTS];
    logic [TOK_W-1:0]            r_slen   [NUM_SEQ_SLOTS];
    logic [BC_W-1:0]             r_sbc    [NUM_SEQ_SLOTS];

    // Memories and their ports.
    logic [BLK_W-1:0]            r_key_mem [LIST_DEPTH];
    logic [BLK_W-1:0]            r_val_mem [LIST_DEPTH];
    logic [REF_W-1:0]            r_ref_mem [NUM_BLOCKS];
    logic [BLK_W-1:0]            r_stk_mem [NUM_BLOCKS];
    logic [BLK_W-1:0]            r_key_rd;
    logic [BLK_W-1:0]            r_val_rd;
    logic [REF_W-1:0]            r_ref_rd;
    logic [BLK_W-1:0]            r_stk_rd;

    logic [LIST_W-1:0]           list_raddr;
    logic [LIST_W-1:0]           list_waddr;
    logic                        key_we;
    logic                        val_we;
    logic [BLK_W-1:0]            key_wdata;
    logic [BLK_W-1:0]            val_wdata;
    logic [BLK_W-1:0]            ref_raddr;
    logic                        ref_we;
    logic [BLK_W-1:0]            ref_waddr;
    logic [REF_W-1:0]            ref_wdata;
    logic [BLK_W-1:0]            stk_raddr;
    logic                        stk_we;
    logic [BLK_W-1:0]            stk_waddr;
    logic [BLK_W-1:0]            stk_wdata;
    logic [REF_W-1:0]            ref_inc;

    // Divider and address unit.
    logic                        r_div_go;
    logic [DVD_W-1:0]            r_dvd;
    logic                        div_done;
    logic [DVD_W-1:0]            div_q;
    logic [TPB_W-1:0]            div_r;
    logic                        r_addr_go;
    logic                        addr_done;
    logic [kvbt_pkg::ADDR_W-1:0] addr_val;

    // Derived values used by the check step.
    logic [16:0]                 need;
    logic [DVD_W-1:0]            new_len;
    logic [BC_W-1:0]             fork_n;
    logic [17:0]                 pop_need;

    function automatic logic [LIST_W-1:0] f_at(input logic [SLOT_W-1:0] s,
                                               input logic [BC_W-1:0] i);
        return LIST_W'(s) * MAX_L + LIST_W'(i);
    endfunction

    // ------------------------------------------------------------------
    // Configuration port.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpb  <= 9'd16;
            r_hc   <= 8'd32;
            r_hw   <= 9'd128;
            r_lc   <= 8'd32;
            r_base <= '0;
        end else if (i_cfg_we) begin
            unique case (kvbt_pkg::t_cfg_idx'(i_cfg_index))
                kvbt_pkg::CFG_TPB:       r_tpb  <= i_cfg_data[TPB_W-1:0];
                kvbt_pkg::CFG_HEADS:     r_hc   <= i_cfg_data[kvbt_pkg::HC_W-1:0];
                kvbt_pkg::CFG_HEAD_W:    r_hw   <= i_cfg_data[kvbt_pkg::HW_W-1:0];
                kvbt_pkg::CFG_LAYERS:    r_lc   <= i_cfg_data[kvbt_pkg::LC_W-1:0];
                kvbt_pkg::CFG_POOL_BASE: r_base <= i_cfg_data[kvbt_pkg::BASE_W-1:0];
                default: ;
            endcase
        end
    end

    // A block size of zero tokens behaves as one token.
    assign tpb_eff = (r_tpb == '0) ? TPB_W'(1) : r_tpb;

    always_comb begin
        geom.tpb  = tpb_eff;
        geom.hc   = r_hc;
        geom.hw   = r_hw;
        geom.lc   = r_lc;
        geom.base = r_base;
    end

    // ------------------------------------------------------------------
    // Check step arithmetic. The quotient is rounded up to count partial blocks.
    // ------------------------------------------------------------------
    always_comb begin
        need     = 17'(div_q) + 17'(div_r != '0);
        new_len  = DVD_W'(r_len) + DVD_W'(r_count);
        fork_n   = (need > 17'(r_bc)) ? r_bc : BC_W'(need);
        pop_need = {need - 17'(r_bc), 1'b0};
        ref_inc  = (r_ref_rd < kvbt_pkg::REF_MAX) ? r_ref_rd + REF_W'(1) : r_ref_rd;
    end

    // ------------------------------------------------------------------
    // Memory port control, by sequencer state.
    // ------------------------------------------------------------------
    assign stk_raddr = BLK_W'(r_top - TOP_W'(1));

    always_comb begin
        list_raddr = f_at(r_ts, r_i);
        list_waddr = f_at(r_ts, r_i);
        key_we     = 1'b0;
        val_we     = 1'b0;
        key_wdata  = r_stk_rd;
        val_wdata  = r_stk_rd;
        ref_raddr  = r_blk;
        ref_we     = 1'b0;
        ref_waddr  = r_blk;
        ref_wdata  = '0;
        stk_we     = 1'b0;
        stk_waddr  = r_top[BLK_W-1:0];
        stk_wdata  = r_blk;
        unique case (r_state)
            S_CLR: begin
                ref_we    = 1'b1;
                ref_waddr = r_clr[BLK_W-1:0];
                ref_wdata = '0;
                stk_we    = 1'b1;
                stk_waddr = r_clr[BLK_W-1:0];
                stk_wdata = r_clr[BLK_W-1:0];
            end
            S_CHK: begin
                list_raddr = f_at(r_ts, BC_W'(div_q));
            end
            S_POPW: begin
                key_we    = !r_vph;
                val_we    = r_vph;
                ref_we    = 1'b1;
                ref_waddr = r_stk_rd;
                ref_wdata = REF_W'(1);
            end
            S_RLR: begin
                ref_raddr = r_vph ? r_val_rd : r_key_rd;
            end
            S_RLU: begin
                ref_we    = (r_ref_rd != '0);
                ref_wdata = r_ref_rd - REF_W'(1);
                stk_we    = (r_ref_rd == REF_W'(1)) && (r_top < TOP_FULL);
            end
            S_CPR: begin
                list_raddr = f_at(r_fs, r_i);
            end
            S_CPK: begin
                key_we    = 1'b1;
                val_we    = 1'b1;
                key_wdata = r_key_rd;
                val_wdata = r_val_rd;
                ref_raddr = r_key_rd;
            end
            S_CPKW: begin
                ref_we    = 1'b1;
                ref_wdata = ref_inc;
            end
            S_CPVR: begin
                ref_raddr = r_blk2;
            end
            S_CPVW: begin
                ref_we    = 1'b1;
                ref_waddr = r_blk2;
                ref_wdata = ref_inc;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (key_we) begin
            r_key_mem[list_waddr] <= key_wdata;
        end
        r_key_rd <= r_key_mem[list_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (val_we) begin
            r_val_mem[list_waddr] <= val_wdata;
        end
        r_val_rd <= r_val_mem[list_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (ref_we) begin
            r_ref_mem[ref_waddr] <= ref_wdata;
        end
        r_ref_rd <= r_ref_mem[ref_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stk_mem[stk_waddr] <= stk_wdata;
        end
        r_stk_rd <= r_stk_mem[stk_raddr];
    end

    // ------------------------------------------------------------------
    // Command sequencer.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr     <= '0;
            r_top     <= TOP_FULL;
            r_valid   <= '0;
            r_ovalid  <= 1'b0;
            r_div_go  <= 1'b0;
            r_addr_go <= 1'b0;
        end else begin
            r_ovalid  <= 1'b0;
            r_div_go  <= 1'b0;
            r_addr_go <= 1'b0;
            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + TOP_W'(1);
                    if (r_clr == CLR_LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_cmd   <= kvbt_pkg::t_cmd'(i_cmd);
                        r_id    <= i_sequence_id;
                        r_child <= i_child_sequence_id;
                        r_count <= i_token_count;
                        r_layer <= i_layer_index;
                        r_pos   <= i_token_position;
                        r_sc    <= '0;
                        r_f     <= 1'b0;
                        r_cf    <= 1'b0;
                        r_ef    <= 1'b0;
                        r_len   <= '0;
                        r_bc    <= '0;
                        r_state <= S_SCAN;
                    end
                end
                // One slot per cycle: first match of the id, any match of the child
                // id, and the lowest free slot.
                S_SCAN: begin
                    if (r_valid[r_sc] && r_tag[r_sc] == r_id && !r_f) begin
                        r_f   <= 1'b1;
                        r_fs  <= r_sc;
                        r_len <= r_slen[r_sc];
                        r_bc  <= r_sbc[r_sc];
                    end
                    if (r_valid[r_sc] && r_tag[r_sc] == r_child) begin
                        r_cf <= 1'b1;
                    end
                    if (!r_valid[r_sc] && !r_ef) begin
                        r_ef <= 1'b1;
                        r_es <= r_sc;
                    end
                    if (r_sc == SLOT_LAST) begin
                        r_state <= S_DISP;
                    end else begin
                        r_sc <= r_sc + SLOT_W'(1);
                    end
                end
                S_DISP: begin
                    r_st    <= kvbt_pkg::ST_OK;
                    r_olen  <= '0;
                    r_oaddr <= '0;
                    r_i     <= '0;
                    r_vph   <= 1'b0;
                    r_state <= S_DONE;
                    r_ts    <= r_fs;
                    unique case (r_cmd)
                        kvbt_pkg::CMD_CREATE: begin
                            if (r_f) begin
                                r_st   <= kvbt_pkg::ST_EXISTS;
                                r_olen <= r_len;
                            end else if (!r_ef) begin
                                r_st <= kvbt_pkg::ST_NO_SLOT;
                            end else begin
                                r_valid[r_es] <= 1'b1;
                                r_tag[r_es]   <= r_id;
                                r_slen[r_es]  <= '0;
                                r_sbc[r_es]   <= '0;
                                r_ts          <= r_es;
                                if (r_count != '0) begin
                                    r_dvd    <= DVD_W'(r_count);
                                    r_div_go <= 1'b1;
                                    r_state  <= S_DIV;
                                end
                            end
                        end
                        kvbt_pkg::CMD_FREE: begin
                            if (!r_f) begin
                                r_st <= kvbt_pkg::ST_NOT_FOUND;
                            end else begin
                                r_state <= S_RLL;
                            end
                        end
                        kvbt_pkg::CMD_APPEND: begin
                            if (!r_f) begin
                                r_st <= kvbt_pkg::ST_NOT_FOUND;
                            end else begin
                                r_dvd    <= new_len;
                                r_div_go <= 1'b1;
                                r_state  <= S_DIV;
                            end
                        end
                        kvbt_pkg::CMD_FORK: begin
                            r_olen <= r_len;
                            if (!r_f) begin
                                r_st <= kvbt_pkg::ST_NOT_FOUND;
                            end else if (r_cf) begin
                                r_st <= kvbt_pkg::ST_EXISTS;
                            end else if (r_pos > r_len) begin
                                r_st <= kvbt_pkg::ST_BAD_POS;
                            end else if (!r_ef) begin
                                r_st <= kvbt_pkg::ST_NO_SLOT;
                            end else begin
                                r_ts     <= r_es;
                                r_dvd    <= DVD_W'(r_pos);
                                r_div_go <= 1'b1;
                                r_state  <= S_DIV;
                            end
                        end
                        kvbt_pkg::CMD_KEY_ADDR, kvbt_pkg::CMD_VALUE_ADDR: begin
                            r_olen <= r_len;
                            if (!r_f) begin
                                r_st <= kvbt_pkg::ST_NOT_FOUND;
                            end else begin
                                r_dvd    <= DVD_W'(r_pos);
                                r_div_go <= 1'b1;
                                r_state  <= S_DIV;
                            end
                        end
                        default: ;
                    endcase
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    r_state <= S_DONE;
                    unique case (r_cmd)
                        kvbt_pkg::CMD_CREATE, kvbt_pkg::CMD_APPEND: begin
                            r_olen <= r_len;
                            if (need > MAX_N || new_len[DVD_W-1]) begin
                                r_st <= kvbt_pkg::ST_TOO_LONG;
                            end else if (need > 17'(r_bc)) begin
                                if (18'(r_top) < pop_need) begin
                                    r_st <= kvbt_pkg::ST_NO_BLOCKS;
                                end else begin
                                    r_i     <= r_bc;
                                    r_end   <= BC_W'(need);
                                    r_state <= S_POPR;
                                end
                            end else begin
                                r_slen[r_ts] <= new_len[TOK_W-1:0];
                                r_olen       <= new_len[TOK_W-1:0];
                            end
                        end
                        kvbt_pkg::CMD_FORK: begin
                            r_end   <= fork_n;
                            r_state <= S_CPR;
                        end
                        kvbt_pkg::CMD_KEY_ADDR, kvbt_pkg::CMD_VALUE_ADDR: begin
                            // The list read for the block id is issued in this cycle.
                            if (r_pos >= r_len || 17'(div_q) >= 17'(r_bc)) begin
                                r_st <= kvbt_pkg::ST_BAD_POS;
                            end else begin
                                r_state <= S_TRR;
                            end
                        end
                        default: ;
                    endcase
                end
                // Each new list position pops a key block and then a value block.
                S_POPR: begin
                    if (r_i == r_end) begin
                        r_sbc[r_ts]  <= r_end;
                        r_slen[r_ts] <= new_len[TOK_W-1:0];
                        r_olen       <= new_len[TOK_W-1:0];
                        r_state      <= S_DONE;
                    end else begin
                        r_top   <= r_top - TOP_W'(1);
                        r_state <= S_POPW;
                    end
                end
                S_POPW: begin
                    r_vph <= !r_vph;
                    if (r_vph) begin
                        r_i <= r_i + BC_W'(1);
                    end
                    r_state <= S_POPR;
                end
                // Release walks the key list, then the value list.
                S_RLL: begin
                    if (r_i == r_bc) begin
                        if (!r_vph) begin
                            r_vph <= 1'b1;
                            r_i   <= '0;
                        end else begin
                            r_valid[r_ts] <= 1'b0;
                            r_state       <= S_DONE;
                        end
                    end else begin
                        r_state <= S_RLR;
                    end
                end
                S_RLR: begin
                    r_blk   <= r_vph ? r_val_rd : r_key_rd;
                    r_state <= S_RLU;
                end
                S_RLU: begin
                    if (r_ref_rd == REF_W'(1) && r_top < TOP_FULL) begin
                        r_top <= r_top + TOP_W'(1);
                    end
                    r_i     <= r_i + BC_W'(1);
                    r_state <= S_RLL;
                end
                // Fork copies each shared position and bumps both counts in turn.
                S_CPR: begin
                    if (r_i == r_end) begin
                        r_valid[r_ts] <= 1'b1;
                        r_tag[r_ts]   <= r_child;
                        r_slen[r_ts]  <= r_pos;
                        r_sbc[r_ts]   <= r_end;
                        r_olen        <= r_pos;
                        r_state       <= S_DONE;
                    end else begin
                        r_state <= S_CPK;
                    end
                end
                S_CPK: begin
                    r_blk   <= r_key_rd;
                    r_blk2  <= r_val_rd;
                    r_state <= S_CPKW;
                end
                S_CPKW: begin
                    r_state <= S_CPVR;
                end
                S_CPVR: begin
                    r_state <= S_CPVW;
                end
                S_CPVW: begin
                    r_i     <= r_i + BC_W'(1);
                    r_state <= S_CPR;
                end
                S_TRR: begin
                    r_blk     <= (r_cmd == kvbt_pkg::CMD_VALUE_ADDR) ? r_val_rd : r_key_rd;
                    r_addr_go <= 1'b1;
                    r_state   <= S_TRA;
                end
                S_TRA: begin
                    if (addr_done) begin
                        r_oaddr <= addr_val;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    kvbt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_go),
        .i_dividend (r_dvd),
        .i_divisor  (tpb_eff),
        .o_done     (div_done),
        .o_quot     (div_q),
        .o_rem      (div_r)
    );

    kvbt_addr #(
        .BLK_W (BLK_W)
    ) u_addr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_addr_go),
        .i_geom  (geom),
        .i_block (r_blk),
        .i_layer (r_layer),
        .i_rem   (div_r),
        .i_value (r_cmd == kvbt_pkg::CMD_VALUE_ADDR),
        .o_done  (addr_done),
        .o_addr  (addr_val)
    );

    // The result registers hold still during the strobe cycle, which is spent in idle.
    assign busy               = (r_state != S_IDLE);
    assign o_valid            = r_ovalid;
    assign o_status           = r_st;
    assign o_element_address  = r_oaddr;
    assign o_sequence_length  = r_olen;
    assign o_free_block_count = kvbt_pkg::FREE_W'(r_top);

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

    a_top_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= TOP_FULL)
        else $error("free stack pointer above the pool size");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    a_strobe_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == S_DONE))
        else $error("result strobe without a finished command");

endmodule

`default_nettype wire

FILE: rtl/kvbt_div.sv
// Restoring divider, one quotient bit per cycle, for token counts by tokens per block.
// Depends on kvbt_pkg.
`default_nettype none

module kvbt_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [kvbt_pkg::DVD_W-1:0]   i_dividend,
    input  wire logic [kvbt_pkg::TPB_W-1:0]   i_divisor,
    output logic                              o_done,
    output logic [kvbt_pkg::DVD_W-1:0]        o_quot,
    output logic [kvbt_pkg::TPB_W-1:0]        o_rem
);

    localparam int DW = kvbt_pkg::DVD_W;
    localparam int RW = kvbt_pkg::TPB_W;

    logic          r_busy;
    logic          r_done;
    logic [4:0]    r_cnt;
    logic [DW-1:0] r_q;
    logic [RW-1:0] r_r;
    logic [RW-1:0] r_d;
    logic [RW:0]   trial;
    logic          ge;
    logic [DW-1:0] n_q;
    logic [RW-1:0] n_r;

    always_comb begin
        trial = {r_r, r_q[DW-1]};
        ge    = trial >= {1'b0, r_d};
        n_r   = ge ? RW'(trial - {1'b0, r_d}) : trial[RW-1:0];
        n_q   = {r_q[DW-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_dividend;
            r_r <= '0;
            r_d <= i_divisor;
        end else if (r_busy) begin
            r_q <= n_q;
            r_r <= n_r;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_r;

endmodule

`default_nettype wire

FILE: rtl/kvbt_addr.sv
// Element address pipeline: products of the block geometry, then the offset sums.
// Depends on kvbt_pkg.
`default_nettype none

module kvbt_addr #(
    parameter int BLK_W = 10
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire kvbt_pkg::t_geom                i_geom,
    input  wire logic [BLK_W-1:0]               i_block,
    input  wire logic [kvbt_pkg::LAYER_W-1:0]   i_layer,
    input  wire logic [kvbt_pkg::TPB_W-1:0]     i_rem,
    input  wire logic                           i_value,
    output logic                                o_done,
    output logic [kvbt_pkg::ADDR_W-1:0]         o_addr
);

    localparam int AW     = kvbt_pkg::ADDR_W;
    localparam int PROD_W = BLK_W + 34;

    logic              r_run;
    logic              r_done;
    logic [2:0]        r_cnt;
    logic [16:0]       r_p1;
    logic [16:0]       r_q1;
    logic [25:0]       r_pb;
    logic [25:0]       r_row;
    logic [33:0]       r_lyr;
    logic [32:0]       r_lay;
    logic [26:0]       r_part;
    logic [PROD_W-1:0] r_blkoff;
    logic [AW-1:0]     r_sum1;
    logic [AW-1:0]     r_sum2;
    logic [AW-1:0]     r_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= 3'd1;
            end else if (r_run) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd5) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Each product is registered before it feeds the next one.
    always_ff @(posedge i_clk) begin
        r_p1     <= 17'(i_geom.tpb * i_geom.hc);
        r_q1     <= 17'(i_geom.hc * i_geom.hw);
        r_pb     <= 26'(r_p1 * i_geom.hw);
        r_row    <= 26'(i_rem * r_q1);
        r_lyr    <= 34'(r_pb * i_geom.lc);
        r_lay    <= 33'(i_layer * r_pb);
        r_part   <= 27'(r_row) + (i_value ? 27'(r_pb) : 27'd0);
        r_blkoff <= PROD_W'(i_block * r_lyr);
        r_sum1   <= AW'(i_geom.base) + AW'({r_lay, 1'b0});
        r_sum2   <= r_sum1 + AW'(r_part);
        r_addr   <= r_sum2 + AW'({r_blkoff, 1'b0});
    end

    assign o_done = r_done;
    assign o_addr = r_addr;

endmodule

`default_nettype wire
